>>> rtl/lsrc_pkg.sv
// lsrc_pkg: shared constants for the line segment rectangle clipper
// register indexes and edge register reset values; no dependencies
`default_nettype none

package lsrc_pkg;

   // register index port width
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // edge register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDGE_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDGE_TOP    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDGE_RIGHT  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDGE_BOTTOM = 2'd3;

   // edge reset values in raw coordinate codes (640 by 480 pixels in q16.8)
   localparam logic [31:0] RST_EDGE_LEFT   = 32'd0;
   localparam logic [31:0] RST_EDGE_TOP    = 32'd0;
   localparam logic [31:0] RST_EDGE_RIGHT  = 32'd163840;
   localparam logic [31:0] RST_EDGE_BOTTOM = 32'd122880;

endpackage

`default_nettype wire

>>> rtl/lsrc_front.sv
// lsrc_front: accepts segment words and classifies them against the left, top, right and bottom edges
// forms deltas, edge distances, magnitudes and ratio signs; uses no package
`default_nettype none

module lsrc_front #(
   parameter int unsigned CW = 24,
   parameter int unsigned EW = 10 * CW + 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic signed [CW-1:0] start_x,
   input  wire logic signed [CW-1:0] start_y,
   input  wire logic signed [CW-1:0] end_x,
   input  wire logic signed [CW-1:0] end_y,
   input  wire logic signed [CW-1:0] edge_left,
   input  wire logic signed [CW-1:0] edge_top,
   input  wire logic signed [CW-1:0] edge_right,
   input  wire logic signed [CW-1:0] edge_bottom,
   input  wire logic                 queue_full,
   output logic                      push,
   output logic [EW-1:0]             entry
);

   logic                 vld_ff, vld_in;
   logic signed [CW:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [CW-1:0]        px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0] x0_ff, y0_ff;
   logic [3:0][CW-1:0]   qa_ff, qa_in;
   logic [3:0]           qn_ff, qn_in, rn_ff, rn_in;
   logic signed [CW:0]   ndx, ndy;
   logic signed [CW:0]   q [0:3];
   logic signed [CW:0]   nq [0:3];
   logic [3:0]           pneg;

   // deltas both ways so the magnitude needs no second add
   always_comb begin
      dx_in = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
      ndx   = {start_x[CW-1], start_x} - {end_x[CW-1], end_x};
      dy_in = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
      ndy   = {start_y[CW-1], start_y} - {end_y[CW-1], end_y};
      px_in = dx_in[CW] ? ndx[CW-1:0] : dx_in[CW-1:0];
      py_in = dy_in[CW] ? ndy[CW-1:0] : dy_in[CW-1:0];
   end

   // signed distances of the start point to each edge
   always_comb begin
      q[0]  = {start_x[CW-1], start_x} - {edge_left[CW-1], edge_left};
      nq[0] = {edge_left[CW-1], edge_left} - {start_x[CW-1], start_x};
      q[1]  = {edge_right[CW-1], edge_right} - {start_x[CW-1], start_x};
      nq[1] = {start_x[CW-1], start_x} - {edge_right[CW-1], edge_right};
      q[2]  = {start_y[CW-1], start_y} - {edge_top[CW-1], edge_top};
      nq[2] = {edge_top[CW-1], edge_top} - {start_y[CW-1], start_y};
      q[3]  = {edge_bottom[CW-1], edge_bottom} - {start_y[CW-1], start_y};
      nq[3] = {start_y[CW-1], start_y} - {edge_bottom[CW-1], edge_bottom};
      pneg[0] = !dx_in[CW] && (dx_in != '0);
      pneg[1] = dx_in[CW];
      pneg[2] = !dy_in[CW] && (dy_in != '0);
      pneg[3] = dy_in[CW];
      for (int e = 0; e < 4; e++) begin
         qn_in[e] = q[e][CW];
         qa_in[e] = q[e][CW] ? nq[e][CW-1:0] : q[e][CW-1:0];
         rn_in[e] = (q[e] != '0) && (q[e][CW] != pneg[e]);
      end
   end

   // hold the word while the queue is full
   assign push   = vld_ff && !queue_full;
   assign vld_in = accept || (vld_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff <= start_x;
         y0_ff <= start_y;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         px_ff <= px_in;
         py_ff <= py_in;
         qa_ff <= qa_in;
         qn_ff <= qn_in;
         rn_ff <= rn_in;
      end
   end

   assign entry = {x0_ff, y0_ff, dx_ff, dy_ff, px_ff, py_ff, qa_ff, qn_ff, rn_ff};

endmodule

`default_nettype wire

>>> rtl/lsrc_queue.sv
// lsrc_queue: two-word queue between the classifying front and the clipping back
// plain register storage with pointers and a fill count; no dependencies
`default_nettype none

module lsrc_queue #(
   parameter int unsigned EW = 250
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [EW-1:0] wdata,
   input  wire logic          pop,
   output logic               full,
   output logic               nonempty,
   output logic [EW-1:0]      rdata
);

   logic [EW-1:0] slot_ff [0:1];
   logic          wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_pop;

   assign full     = cnt_ff[1];
   assign nonempty = cnt_ff != 2'd0;
   assign rdata    = slot_ff[rptr_ff];
   assign do_pop   = pop && nonempty;

   // pointer and fill count update
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lsrc_back.sv
// lsrc_back: ratio dividers, edge resolve, endpoint interpolation and result register
// one quotient bit per stage for each edge; uses no package
`default_nettype none

module lsrc_back #(
   parameter int unsigned CW = 24,
   parameter int unsigned PF = 16,
   parameter int unsigned EW = 10 * CW + 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [EW-1:0]        entry,
   output logic                      rsp_strobe,
   output logic                      rsp_visible,
   output logic signed [CW-1:0]      rsp_clip_start_x,
   output logic signed [CW-1:0]      rsp_clip_start_y,
   output logic signed [CW-1:0]      rsp_clip_end_x,
   output logic signed [CW-1:0]      rsp_clip_end_y
);

   localparam int unsigned ND = PF + 1;
   localparam int unsigned PW = PF + CW + 3;
   localparam int unsigned SW = CW + 4;
   localparam logic [PF+1:0] T_ONE  = (PF + 2)'(1) << PF;
   localparam logic [PF+1:0] T_OVER = T_ONE + (PF + 2)'(1);

   // unpack the queued word
   logic signed [CW-1:0] e_x0, e_y0;
   logic signed [CW:0]   e_dx, e_dy;
   logic [CW-1:0]        e_px, e_py;
   logic [3:0][CW-1:0]   e_qa;
   logic [3:0]           e_qn, e_rn;

   assign {e_x0, e_y0, e_dx, e_dy, e_px, e_py, e_qa, e_qn, e_rn} = entry;

   // divider pipeline, index 0 is the setup stage
   logic                 dv_vld_ff [0:ND];
   logic signed [CW-1:0] dv_x0_ff  [0:ND];
   logic signed [CW-1:0] dv_y0_ff  [0:ND];
   logic signed [CW:0]   dv_dx_ff  [0:ND];
   logic signed [CW:0]   dv_dy_ff  [0:ND];
   logic [CW-1:0]        dv_px_ff  [0:ND];
   logic [CW-1:0]        dv_py_ff  [0:ND];
   logic [3:0]           dv_qn_ff  [0:ND];
   logic [3:0]           dv_rn_ff  [0:ND];
   logic [3:0]           dv_sat_ff [0:ND];
   logic [3:0][CW:0]     dv_rem_ff [0:ND];
   logic [3:0][ND-1:0]   dv_quo_ff [0:ND];
   logic [3:0]           sat_in;

   // setup: a ratio of two or more is past every comparison point
   always_comb begin
      sat_in[0] = {1'b0, e_qa[0]} >= {e_px, 1'b0};
      sat_in[1] = {1'b0, e_qa[1]} >= {e_px, 1'b0};
      sat_in[2] = {1'b0, e_qa[2]} >= {e_py, 1'b0};
      sat_in[3] = {1'b0, e_qa[3]} >= {e_py, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dv_x0_ff[0]  <= e_x0;
      dv_y0_ff[0]  <= e_y0;
      dv_dx_ff[0]  <= e_dx;
      dv_dy_ff[0]  <= e_dy;
      dv_px_ff[0]  <= e_px;
      dv_py_ff[0]  <= e_py;
      dv_qn_ff[0]  <= e_qn;
      dv_rn_ff[0]  <= e_rn;
      dv_sat_ff[0] <= sat_in;
      for (int e = 0; e < 4; e++) begin
         dv_rem_ff[0][e] <= {1'b0, e_qa[e]};
         dv_quo_ff[0][e] <= '0;
      end
   end

   // restoring division steps
   for (genvar s = 0; s < ND; s++) begin : g_div
      logic [3:0][CW:0]   rem_in;
      logic [3:0][ND-1:0] quo_in;
      logic [CW:0]        dvs [0:3];
      logic [CW:0]        diff [0:3];
      logic [3:0]         ge;

      always_comb begin
         dvs[0] = {1'b0, dv_px_ff[s]};
         dvs[1] = {1'b0, dv_px_ff[s]};
         dvs[2] = {1'b0, dv_py_ff[s]};
         dvs[3] = {1'b0, dv_py_ff[s]};
         for (int e = 0; e < 4; e++) begin
            ge[e]     = dv_rem_ff[s][e] >= dvs[e];
            diff[e]   = ge[e] ? dv_rem_ff[s][e] - dvs[e] : dv_rem_ff[s][e];
            rem_in[e] = {diff[e][CW-1:0], 1'b0};
            quo_in[e] = {dv_quo_ff[s][e][ND-2:0], ge[e]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s+1] <= 1'b0;
         end else begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         dv_x0_ff[s+1]  <= dv_x0_ff[s];
         dv_y0_ff[s+1]  <= dv_y0_ff[s];
         dv_dx_ff[s+1]  <= dv_dx_ff[s];
         dv_dy_ff[s+1]  <= dv_dy_ff[s];
         dv_px_ff[s+1]  <= dv_px_ff[s];
         dv_py_ff[s+1]  <= dv_py_ff[s];
         dv_qn_ff[s+1]  <= dv_qn_ff[s];
         dv_rn_ff[s+1]  <= dv_rn_ff[s];
         dv_sat_ff[s+1] <= dv_sat_ff[s];
         dv_rem_ff[s+1] <= rem_in;
         dv_quo_ff[s+1] <= quo_in;
      end
   end

   // clamp ratios: negatives act as minus one lsb, large ones as one plus one lsb
   logic signed [PF+1:0] r [0:3];
   logic [PF+1:0]        mag [0:3];
   logic [3:0]           pneg, pzero;
   logic                 vis_in;
   logic [PF:0]          t0_in, t1_in;

   always_comb begin
      pzero[0] = dv_px_ff[ND] == '0;
      pzero[1] = pzero[0];
      pzero[2] = dv_py_ff[ND] == '0;
      pzero[3] = pzero[2];
      pneg[0]  = !dv_dx_ff[ND][CW];
      pneg[1]  = dv_dx_ff[ND][CW];
      pneg[2]  = !dv_dy_ff[ND][CW];
      pneg[3]  = dv_dy_ff[ND][CW];
      for (int e = 0; e < 4; e++) begin
         mag[e] = {1'b0, dv_quo_ff[ND][e]};
         if (dv_sat_ff[ND][e] || (mag[e] > T_OVER)) begin
            mag[e] = T_OVER;
         end
         if (dv_rn_ff[ND][e] && (mag[e] != '0)) begin
            r[e] = -(PF + 2)'(1);
         end else begin
            r[e] = $signed(mag[e]);
         end
      end
   end

   // walk the edges left, right, top, bottom
   always_comb begin
      vis_in = 1'b1;
      t0_in  = '0;
      t1_in  = T_ONE[PF:0];
      for (int e = 0; e < 4; e++) begin
         if (vis_in) begin
            if (pzero[e]) begin
               if (dv_qn_ff[ND][e]) begin
                  vis_in = 1'b0;
               end
            end else if (pneg[e]) begin
               if (r[e] > $signed({1'b0, t1_in})) begin
                  vis_in = 1'b0;
               end else if (r[e] > $signed({1'b0, t0_in})) begin
                  t0_in = r[e][PF:0];
               end
            end else begin
               if (r[e] < $signed({1'b0, t0_in})) begin
                  vis_in = 1'b0;
               end else if (r[e] < $signed({1'b0, t1_in})) begin
                  t1_in = r[e][PF:0];
               end
            end
         end
      end
   end

   logic                 rs_vld_ff, rs_vis_ff;
   logic [PF:0]          rs_t0_ff, rs_t1_ff;
   logic signed [CW-1:0] rs_x0_ff, rs_y0_ff;
   logic signed [CW:0]   rs_dx_ff, rs_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_vld_ff <= 1'b0;
      end else begin
         rs_vld_ff <= dv_vld_ff[ND];
      end
   end

   always_ff @(posedge clock) begin
      rs_vis_ff <= vis_in;
      rs_t0_ff  <= t0_in;
      rs_t1_ff  <= t1_in;
      rs_x0_ff  <= dv_x0_ff[ND];
      rs_y0_ff  <= dv_y0_ff[ND];
      rs_dx_ff  <= dv_dx_ff[ND];
      rs_dy_ff  <= dv_dy_ff[ND];
   end

   // parameter times delta for each output coordinate
   logic                 ml_vld_ff, ml_vis_ff;
   logic signed [PW-1:0] ml_prod_ff [0:3];
   logic signed [CW-1:0] ml_x0_ff, ml_y0_ff;
   logic signed [CW:0]   ml_dx_ff, ml_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_vld_ff <= 1'b0;
      end else begin
         ml_vld_ff <= rs_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      ml_vis_ff     <= rs_vis_ff;
      ml_prod_ff[0] <= PW'($signed({1'b0, rs_t0_ff}) * rs_dx_ff);
      ml_prod_ff[1] <= PW'($signed({1'b0, rs_t0_ff}) * rs_dy_ff);
      ml_prod_ff[2] <= PW'($signed({1'b0, rs_t1_ff}) * rs_dx_ff);
      ml_prod_ff[3] <= PW'($signed({1'b0, rs_t1_ff}) * rs_dy_ff);
      ml_x0_ff      <= rs_x0_ff;
      ml_y0_ff      <= rs_y0_ff;
      ml_dx_ff      <= rs_dx_ff;
      ml_dy_ff      <= rs_dy_ff;
   end

   // round to nearest, add to the start point, saturate
   logic signed [PW-1:0] rnd  [0:3];
   logic signed [SW-1:0] sum  [0:3];
   logic signed [CW-1:0] clip [0:3];
   logic signed [CW-1:0] base [0:3];
   logic signed [CW-1:0] orig_x1, orig_y1;

   always_comb begin
      base[0] = ml_x0_ff;
      base[1] = ml_y0_ff;
      base[2] = ml_x0_ff;
      base[3] = ml_y0_ff;
      for (int e = 0; e < 4; e++) begin
         rnd[e] = ml_prod_ff[e] + (PW'(1) << (PF - 1));
         sum[e] = SW'(rnd[e] >>> PF) + {{4{base[e][CW-1]}}, base[e]};
         if (!sum[e][SW-1] && (sum[e][SW-2:CW-1] != '0)) begin
            clip[e] = {1'b0, {(CW - 1){1'b1}}};
         end else if (sum[e][SW-1] && (sum[e][SW-2:CW-1] != '1)) begin
            clip[e] = {1'b1, {(CW - 1){1'b0}}};
         end else begin
            clip[e] = sum[e][CW-1:0];
         end
      end
      orig_x1 = ml_x0_ff + ml_dx_ff[CW-1:0];
      orig_y1 = ml_y0_ff + ml_dy_ff[CW-1:0];
   end

   logic                 out_vld_ff, out_vis_ff;
   logic signed [CW-1:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= ml_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_vis_ff <= ml_vis_ff;
      out_sx_ff  <= ml_vis_ff ? clip[0] : ml_x0_ff;
      out_sy_ff  <= ml_vis_ff ? clip[1] : ml_y0_ff;
      out_ex_ff  <= ml_vis_ff ? clip[2] : orig_x1;
      out_ey_ff  <= ml_vis_ff ? clip[3] : orig_y1;
   end

   assign rsp_strobe       = out_vld_ff;
   assign rsp_visible      = out_vis_ff;
   assign rsp_clip_start_x = out_sx_ff;
   assign rsp_clip_start_y = out_sy_ff;
   assign rsp_clip_end_x   = out_ex_ff;
   assign rsp_clip_end_y   = out_ey_ff;

endmodule

`default_nettype wire

>>> rtl/line_segment_rect_clipper_core.sv
// line segment rectangle clipper, top level
// path: front register, queue slot, divider setup and steps, resolve, multiply and result registers
// throughput: one segment per cycle, set by the per-edge divider pipelines
// busy rises only if the queue fills, which cannot happen as the result side never waits
// synchronous reset clears the edge registers to 0, 0, 640.0, 480.0 px and empties the pipe
`default_nettype none

module line_segment_rect_clipper_core #(
   parameter int unsigned COORD_WIDTH     = 24,
   parameter int unsigned PARAM_FRAC_BITS = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         start,
   output logic                                              busy,
   input  wire logic signed [COORD_WIDTH-1:0]                req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0]                req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0]                req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0]                req_end_y,
   output logic                                              rsp_strobe,
   output logic                                              rsp_visible,
   output logic signed [COORD_WIDTH-1:0]                     rsp_clip_start_x,
   output logic signed [COORD_WIDTH-1:0]                     rsp_clip_start_y,
   output logic signed [COORD_WIDTH-1:0]                     rsp_clip_end_x,
   output logic signed [COORD_WIDTH-1:0]                     rsp_clip_end_y,
   input  wire logic                                         csr_write_en,
   input  wire logic [lsrc_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  wire logic [COORD_WIDTH-1:0]                       csr_wdata
);

   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned EW = 10 * CW + 10;

   // edge registers
   logic signed [CW-1:0] left_ff, top_ff, right_ff, bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= lsrc_pkg::RST_EDGE_LEFT[CW-1:0];
         top_ff    <= lsrc_pkg::RST_EDGE_TOP[CW-1:0];
         right_ff  <= lsrc_pkg::RST_EDGE_RIGHT[CW-1:0];
         bottom_ff <= lsrc_pkg::RST_EDGE_BOTTOM[CW-1:0];
      end else if (csr_write_en) begin
         case (csr_index)
            lsrc_pkg::REG_EDGE_LEFT:   left_ff   <= csr_wdata;
            lsrc_pkg::REG_EDGE_TOP:    top_ff    <= csr_wdata;
            lsrc_pkg::REG_EDGE_RIGHT:  right_ff  <= csr_wdata;
            lsrc_pkg::REG_EDGE_BOTTOM: bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic          accept, push, q_full, q_nonempty;
   logic [EW-1:0] f_entry, q_head;

   assign busy   = q_full;
   assign accept = start && !q_full;

   // front: take and classify words
   lsrc_front #(
      .CW (CW),
      .EW (EW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .start_x     (req_start_x),
      .start_y     (req_start_y),
      .end_x       (req_end_x),
      .end_y       (req_end_y),
      .edge_left   (left_ff),
      .edge_top    (top_ff),
      .edge_right  (right_ff),
      .edge_bottom (bottom_ff),
      .queue_full  (q_full),
      .push        (push),
      .entry       (f_entry)
   );

   // queue between the halves
   lsrc_queue #(
      .EW (EW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wdata    (f_entry),
      .pop      (q_nonempty),
      .full     (q_full),
      .nonempty (q_nonempty),
      .rdata    (q_head)
   );

   // back: divide, resolve, interpolate
   lsrc_back #(
      .CW (CW),
      .PF (PARAM_FRAC_BITS),
      .EW (EW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (q_nonempty),
      .entry            (q_head),
      .rsp_strobe       (rsp_strobe),
      .rsp_visible      (rsp_visible),
      .rsp_clip_start_x (rsp_clip_start_x),
      .rsp_clip_start_y (rsp_clip_start_y),
      .rsp_clip_end_x   (rsp_clip_end_x),
      .rsp_clip_end_y   (rsp_clip_end_y)
   );

endmodule

`default_nettype wire
